// ===== rtl/core/hrf_pkg.sv =====
// ---------------------------------------------------------------------------
// hrf_pkg: shared definitions for the HTTP request framer
// Byte codes, the content-length key text, counter sizing and the state
// encoding of the header value parser.
// ---------------------------------------------------------------------------
package hrf_pkg;

	// Width of the body byte counter; it saturates at its all-ones value.
	localparam int COUNT_WIDTH = 32;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	// Key matching: number of characters in "content-length: ", and the
	// position code that marks a line whose prefix did not match.
	localparam int KEY_LEN_I = 16;
	localparam int KEY_POS_W = 5;
	localparam int KEY_IDX_W = $clog2(KEY_LEN_I);
	localparam logic [KEY_POS_W-1:0] KEY_LEN  = KEY_POS_W'(KEY_LEN_I);
	localparam logic [KEY_POS_W-1:0] KEY_MISS = '1;

	// Lower-case key text, one character per position.
	function automatic logic [7:0] key_char(input logic [KEY_IDX_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h63;
			4'd1:    ch = 8'h6F;
			4'd2:    ch = 8'h6E;
			4'd3:    ch = 8'h74;
			4'd4:    ch = 8'h65;
			4'd5:    ch = 8'h6E;
			4'd6:    ch = 8'h74;
			4'd7:    ch = 8'h2D;
			4'd8:    ch = 8'h6C;
			4'd9:    ch = 8'h65;
			4'd10:   ch = 8'h6E;
			4'd11:   ch = 8'h67;
			4'd12:   ch = 8'h74;
			4'd13:   ch = 8'h68;
			4'd14:   ch = 8'h3A;
			default: ch = 8'h20;
		endcase
		return ch;
	endfunction

	// Character codes.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// Progress through the CR LF CR LF terminator.
	localparam logic [1:0] TP_NONE   = 2'd0;
	localparam logic [1:0] TP_CR     = 2'd1;
	localparam logic [1:0] TP_CRLF   = 2'd2;
	localparam logic [1:0] TP_CRLFCR = 2'd3;

	// Accumulator holds magnitudes up to 2^31; the candidate needs 4 more bits.
	localparam int ACC_W  = 32;
	localparam int PROD_W = ACC_W + 4;
	localparam logic [PROD_W-1:0] NEG_MAG_LIMIT = PROD_W'(64'd2147483648);

	typedef enum logic [3:0] {
		VP_SKIP   = 4'b0001,
		VP_SIGN   = 4'b0010,
		VP_DIGITS = 4'b0100,
		VP_STOP   = 4'b1000
	} value_phase_t;

endpackage

// ===== rtl/core/http_request_framer_unit.sv =====
// ---------------------------------------------------------------------------
// http_request_framer_unit: HTTP/1.1 header end and Content-Length framing
// Timing: a result beat is captured in the output register when its input beat is accepted.
// Throughput: one byte per clock cycle while the output is not stalled, set by the single output register.
// Reset: arst_n clears the framing state and the output valid at once.
// ---------------------------------------------------------------------------
// Each accepted byte is passed straight through with framing flags. The
// parser state (terminator progress, key match position, value parser,
// committed length and body counter) is updated in the same cycle in which
// the byte is accepted, and the result beat is captured in the output
// register. A new byte is taken whenever that register is empty or is being
// drained, so bytes may follow one another without a gap.
//
// The header ends at the first CR LF CR LF. Each header line after the
// request line is checked for a case-insensitive "content-length: " prefix;
// the rest of the line is then parsed as a signed decimal and committed when
// the line ends, the last such line winning. Once in the body, bytes are
// counted and the request completes when the count reaches the length, after
// which all state returns to its reset values.
// ---------------------------------------------------------------------------
module http_request_framer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_out,
	output logic        in_body,
	output logic        header_end,
	output logic        request_done,
	output logic [30:0] length_value,
	output logic        length_is_negative,
	output logic [31:0] body_bytes
);

	// Framing state.
	logic                                body_q, body_n;
	logic [1:0]                          tp_q, tp_n;
	logic                                reqline_q, reqline_n;
	logic [hrf_pkg::KEY_POS_W-1:0]       key_pos_q, key_pos_n;
	hrf_pkg::value_phase_t               vphase_q, vphase_n;
	logic [hrf_pkg::ACC_W-1:0]           accum_q, accum_n;
	logic                                minus_q, minus_n;
	logic                                invalid_q, invalid_n;
	logic [30:0]                         len_q, len_n;
	logic                                neg_q, neg_n;
	logic [hrf_pkg::COUNT_WIDTH-1:0]     cnt_q, cnt_n;

	// Result of the current byte.
	logic                                body_flag;
	logic                                hend_flag;
	logic                                done_flag;
	logic [31:0]                         bytes_sat;

	// Helpers for the character classes.
	logic                                accept;
	logic                                is_digit;
	logic                                is_ws;
	logic [7:0]                          folded;
	logic [hrf_pkg::PROD_W-1:0]          prod;
	logic [63:0]                         cnt_wide;

	// Output register.
	logic                                out_valid_s1;
	logic [7:0]                          byte_s1;
	logic                                body_s1;
	logic                                hend_s1;
	logic                                done_s1;
	logic [30:0]                         len_s1;
	logic                                neg_s1;
	logic [31:0]                         bytes_s1;

	// A byte can enter whenever the result register is free or being taken.
	assign in_stall = out_valid_s1 & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign is_digit = (data_byte >= hrf_pkg::CH_ZERO) && (data_byte <= hrf_pkg::CH_NINE);
	assign is_ws    = data_byte inside {8'h20, [8'h09:8'h0D]};
	assign folded   = ((data_byte >= hrf_pkg::CH_UP_A) && (data_byte <= hrf_pkg::CH_UP_Z))
	                  ? (data_byte | hrf_pkg::CASE_BIT) : data_byte;

	// accum * 10 + digit, built from two shifts and an add.
	assign prod = {accum_q, 3'b000} + {2'b00, accum_q, 1'b0}
	              + hrf_pkg::PROD_W'(data_byte - hrf_pkg::CH_ZERO);

	always_comb begin
		body_n    = body_q;
		tp_n      = tp_q;
		reqline_n = reqline_q;
		key_pos_n = key_pos_q;
		vphase_n  = vphase_q;
		accum_n   = accum_q;
		minus_n   = minus_q;
		invalid_n = invalid_q;
		len_n     = len_q;
		neg_n     = neg_q;
		cnt_n     = cnt_q;
		body_flag = 1'b0;
		hend_flag = 1'b0;
		done_flag = 1'b0;

		if (body_q) begin
			// Body byte: count it and test for completion.
			body_flag = 1'b1;
			if (cnt_q != hrf_pkg::CNT_MAX) begin
				cnt_n = cnt_q + 1'b1;
			end
			if (!neg_q && (64'(cnt_n) >= 64'(len_q))) begin
				done_flag = 1'b1;
			end
		end else if ((data_byte == hrf_pkg::CH_LF) && (tp_q == hrf_pkg::TP_CRLFCR)) begin
			// Blank line: the header is over.
			hend_flag = 1'b1;
			tp_n      = hrf_pkg::TP_NONE;
			body_n    = 1'b1;
			cnt_n     = '0;
			key_pos_n = '0;
			vphase_n  = hrf_pkg::VP_SKIP;
			accum_n   = '0;
			minus_n   = 1'b0;
			invalid_n = 1'b0;
			if (!neg_q && (len_q == '0)) begin
				done_flag = 1'b1;
			end
		end else if ((data_byte == hrf_pkg::CH_LF) && (tp_q == hrf_pkg::TP_CR)) begin
			// End of a line: commit a parsed length if the key matched.
			if (!reqline_q && (key_pos_q == hrf_pkg::KEY_LEN)) begin
				len_n = '0;
				neg_n = 1'b0;
				if (((vphase_q == hrf_pkg::VP_DIGITS) || (vphase_q == hrf_pkg::VP_STOP))
				    && !invalid_q) begin
					if (minus_q) begin
						neg_n = (accum_q != '0);
					end else if (!accum_q[hrf_pkg::ACC_W-1]) begin
						len_n = accum_q[30:0];
					end
				end
			end
			reqline_n = 1'b0;
			key_pos_n = '0;
			vphase_n  = hrf_pkg::VP_SKIP;
			accum_n   = '0;
			minus_n   = 1'b0;
			invalid_n = 1'b0;
			tp_n      = hrf_pkg::TP_CRLF;
		end else begin
			if (data_byte == hrf_pkg::CH_CR) begin
				tp_n = (tp_q == hrf_pkg::TP_CRLF) ? hrf_pkg::TP_CRLFCR : hrf_pkg::TP_CR;
			end else begin
				tp_n = hrf_pkg::TP_NONE;
			end

			if (!reqline_q) begin
				if (key_pos_q < hrf_pkg::KEY_LEN) begin
					// Still matching the key prefix.
					if (folded == hrf_pkg::key_char(key_pos_q[hrf_pkg::KEY_IDX_W-1:0])) begin
						key_pos_n = key_pos_q + 1'b1;
					end else begin
						key_pos_n = hrf_pkg::KEY_MISS;
					end
				end else if (key_pos_q == hrf_pkg::KEY_LEN) begin
					// Value parser: whitespace, optional sign, then digits.
					case (vphase_q)
						hrf_pkg::VP_SKIP: begin
							if (is_ws) begin
								vphase_n = hrf_pkg::VP_SKIP;
							end else if (data_byte == hrf_pkg::CH_PLUS) begin
								vphase_n = hrf_pkg::VP_SIGN;
							end else if (data_byte == hrf_pkg::CH_MINUS) begin
								minus_n  = 1'b1;
								vphase_n = hrf_pkg::VP_SIGN;
							end else if (is_digit) begin
								if (prod > hrf_pkg::NEG_MAG_LIMIT) begin
									invalid_n = 1'b1;
								end else begin
									accum_n = prod[hrf_pkg::ACC_W-1:0];
								end
								vphase_n = hrf_pkg::VP_DIGITS;
							end else begin
								invalid_n = 1'b1;
								vphase_n  = hrf_pkg::VP_STOP;
							end
						end
						hrf_pkg::VP_SIGN, hrf_pkg::VP_DIGITS: begin
							if (is_digit) begin
								if (prod > hrf_pkg::NEG_MAG_LIMIT) begin
									invalid_n = 1'b1;
								end else begin
									accum_n = prod[hrf_pkg::ACC_W-1:0];
								end
								vphase_n = hrf_pkg::VP_DIGITS;
							end else begin
								// A sign with no digit after it is invalid.
								if (vphase_q == hrf_pkg::VP_SIGN) begin
									invalid_n = 1'b1;
								end
								vphase_n = hrf_pkg::VP_STOP;
							end
						end
						default: begin
							vphase_n = vphase_q;
						end
					endcase
				end
			end
		end
	end

	// Body count as reported, saturated to 32 bits when the counter is wider.
	assign cnt_wide  = 64'(cnt_n);
	assign bytes_sat = (cnt_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : cnt_wide[31:0];

	// Framing state; a completed request returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q    <= 1'b0;
			tp_q      <= hrf_pkg::TP_NONE;
			reqline_q <= 1'b1;
			key_pos_q <= '0;
			vphase_q  <= hrf_pkg::VP_SKIP;
			accum_q   <= '0;
			minus_q   <= 1'b0;
			invalid_q <= 1'b0;
			len_q     <= '0;
			neg_q     <= 1'b0;
			cnt_q     <= '0;
		end else if (accept) begin
			if (done_flag) begin
				body_q    <= 1'b0;
				tp_q      <= hrf_pkg::TP_NONE;
				reqline_q <= 1'b1;
				key_pos_q <= '0;
				vphase_q  <= hrf_pkg::VP_SKIP;
				accum_q   <= '0;
				minus_q   <= 1'b0;
				invalid_q <= 1'b0;
				len_q     <= '0;
				neg_q     <= 1'b0;
				cnt_q     <= '0;
			end else begin
				body_q    <= body_n;
				tp_q      <= tp_n;
				reqline_q <= reqline_n;
				key_pos_q <= key_pos_n;
				vphase_q  <= vphase_n;
				accum_q   <= accum_n;
				minus_q   <= minus_n;
				invalid_q <= invalid_n;
				len_q     <= len_n;
				neg_q     <= neg_n;
				cnt_q     <= cnt_n;
			end
		end
	end

	// Output beat valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (accept) begin
			out_valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s1 <= 1'b0;
		end
	end

	// Output beat payload, reported before any post-completion reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1  <= data_byte;
			body_s1  <= body_flag;
			hend_s1  <= hend_flag;
			done_s1  <= done_flag;
			len_s1   <= len_n;
			neg_s1   <= neg_n;
			bytes_s1 <= bytes_sat;
		end
	end

	assign out_valid          = out_valid_s1;
	assign byte_out           = byte_s1;
	assign in_body            = body_s1;
	assign header_end         = hend_s1;
	assign request_done       = done_s1;
	assign length_value       = len_s1;
	assign length_is_negative = neg_s1;
	assign body_bytes         = bytes_s1;

endmodule
